// ===== hw/rtl/sllc_pkg.sv =====
// shared types, constants and helpers for the linked list node pool
`timescale 1ns / 1ps

package sllc_pkg;

  localparam int POOL_DEPTH  = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(POOL_DEPTH);
  // one extra code above the node range serves as the null link
  localparam int IDX_W       = $clog2(POOL_DEPTH + 1);
  localparam logic [IDX_W-1:0] NIL = IDX_W'(POOL_DEPTH);

  typedef enum logic [3:0] {
    OP_INSFIRST = 4'd0,
    OP_TOHEAD   = 4'd1,
    OP_READHEAD = 4'd2,
    OP_DELHEAD  = 4'd3,
    OP_DELAFTER = 4'd4,
    OP_INSAFTER = 4'd5,
    OP_READ     = 4'd6,
    OP_WRITE    = 4'd7,
    OP_ADVANCE  = 4'd8,
    OP_QUERY    = 4'd9,
    OP_DISPOSE  = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_NO_CURSOR = 2'd2,
    STS_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DA2,
    ST_DA3,
    ST_IA2,
    ST_IA3,
    ST_DISP,
    ST_HOLD
  } state_t;

  // node memory request for the link and value ports
  typedef struct packed {
    logic [IDX_W-1:0]       next_ra;
    logic                   next_we;
    logic [IDX_W-1:0]       next_wa;
    logic [IDX_W-1:0]       next_wd;
    logic [IDX_W-1:0]       value_ra;
    logic                   value_we;
    logic [IDX_W-1:0]       value_wa;
    logic [VALUE_WIDTH-1:0] value_wd;
  } mem_req_t;

  function automatic logic is_node(input logic [IDX_W-1:0] x);
    return x < IDX_W'(POOL_DEPTH);
  endfunction

  function automatic logic [IDX_W-1:0] norm_link(input logic [IDX_W-1:0] x);
    return is_node(x) ? x : NIL;
  endfunction

  // sign extend a stored value to the 32-bit result field
  function automatic logic [31:0] to_read_value(input logic [VALUE_WIDTH-1:0] v);
    return 32'(signed'(v));
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] to_stored(input logic [31:0] v);
    return VALUE_WIDTH'(signed'(v));
  endfunction

endpackage

// ===== hw/rtl/sllc_node_mem.sv =====
// node value and link memories with registered read data
`timescale 1ns / 1ps

module sllc_node_mem import sllc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mem_req_t               req,
  output logic [IDX_W-1:0]       next_rdata,
  output logic [VALUE_WIDTH-1:0] value_rdata
);

  logic [IDX_W-1:0]       next_mem  [POOL_DEPTH];
  logic [VALUE_WIDTH-1:0] value_mem [POOL_DEPTH];

  // a link never written reads as its reset chain value i+1
  logic [POOL_DEPTH-1:0] next_vld_r;
  logic [IDX_W-1:0]      next_q_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic                  rd_vld_r;
  logic [VALUE_WIDTH-1:0] value_q_r;

  always_ff @(posedge clk) begin
    if (req.next_we) begin
      next_mem[req.next_wa[ADDR_W-1:0]] <= req.next_wd;
    end
    next_q_r <= next_mem[req.next_ra[ADDR_W-1:0]];
    rd_idx_r <= req.next_ra;
  end

  always_ff @(posedge clk) begin
    if (req.value_we) begin
      value_mem[req.value_wa[ADDR_W-1:0]] <= req.value_wd;
    end
    value_q_r <= value_mem[req.value_ra[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= next_vld_r[req.next_ra[ADDR_W-1:0]];
      if (req.next_we) begin
        next_vld_r[req.next_wa[ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  assign next_rdata  = rd_vld_r ? next_q_r : IDX_W'(rd_idx_r + 1'b1);
  assign value_rdata = value_q_r;

endmodule

// ===== hw/rtl/singly_linked_list_with_cursor_top.sv =====
// singly linked list in a node pool with free list, head pointer and cursor
//
// input channel: in_tuser carries the operation code, in_tdata the value.
// one transfer in gives exactly one transfer out on the result channel:
// read value, cursor active flag and status code.
// the result is registered once the execute state finishes for most
// operations; insert after cursor and a delete after cursor that unlinks a
// node go on through ST_IA2, ST_IA3 or ST_DA2, ST_DA3, and dispose walks the
// whole list in ST_DISP, releasing one node per cycle through the link memory
// read port. in_tready is high only while no item is in work, so a new item is
// taken only after the last one finishes its node memory read then write.
// reset: head and cursor null, free list chained 0,1,2,... through per-entry
// valid bits on the link memory, so no clearing pass is needed; node values
// are undefined until written. an item may follow right after reset.
// when the receiver stalls, the finished result parks in a hold register and
// the block accepts nothing new until that result moves to the result register.
`timescale 1ns / 1ps

module singly_linked_list_with_cursor_top import sllc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [3:0]  in_tuser,   // [3:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] read_value, [32] cursor_active, [39:33] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  state_t                 state_r, state_nxt;
  logic [3:0]             op_r, op_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]       head_r, head_nxt;
  logic [IDX_W-1:0]       cursor_r, cursor_nxt;
  logic [IDX_W-1:0]       free_r, free_nxt;
  logic [IDX_W-1:0]       tmp_r, tmp_nxt;     // node being unlinked or inserted
  logic                   err_r, err_nxt;

  // result register toward the receiver
  logic                   out_valid_r, out_valid_nxt;
  logic [31:0]            out_rd_r, out_rd_nxt;
  logic                   out_act_r, out_act_nxt;
  status_t                out_sts_r, out_sts_nxt;

  // parked result while the receiver stalls
  logic [31:0]            pend_rd_r, pend_rd_nxt;
  logic                   pend_act_r, pend_act_nxt;
  status_t                pend_sts_r, pend_sts_nxt;

  mem_req_t               mreq;
  logic [IDX_W-1:0]       next_rdata;
  logic [VALUE_WIDTH-1:0] value_rdata;
  logic [IDX_W-1:0]       nn;

  logic                   fin;
  logic [31:0]            res_rd;
  status_t                res_sts;
  logic                   out_free;

  sllc_node_mem u_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (mreq),
    .next_rdata  (next_rdata),
    .value_rdata (value_rdata)
  );

  assign nn        = norm_link(next_rdata);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= NIL;
      cursor_r    <= NIL;
      free_r      <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cursor_r    <= cursor_nxt;
      free_r      <= free_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    tmp_r      <= tmp_nxt;
    out_rd_r   <= out_rd_nxt;
    out_act_r  <= out_act_nxt;
    out_sts_r  <= out_sts_nxt;
    pend_rd_r  <= pend_rd_nxt;
    pend_act_r <= pend_act_nxt;
    pend_sts_r <= pend_sts_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    head_nxt      = head_r;
    cursor_nxt    = cursor_r;
    free_nxt      = free_r;
    tmp_nxt       = tmp_r;
    err_nxt       = err_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_rd_nxt    = out_rd_r;
    out_act_nxt   = out_act_r;
    out_sts_nxt   = out_sts_r;
    pend_rd_nxt   = pend_rd_r;
    pend_act_nxt  = pend_act_r;
    pend_sts_nxt  = pend_sts_r;
    mreq          = '0;
    mreq.next_ra  = head_r;
    mreq.value_ra = head_r;
    fin           = 1'b0;
    res_rd        = '0;
    res_sts       = STS_OK;

    case (state_r)
      ST_IDLE: begin
        // issue the first read together with the input transfer
        if (in_tvalid) begin
          op_nxt  = in_tuser;
          val_nxt = to_stored(in_tdata);
          if (in_tuser == OP_INSFIRST || in_tuser == OP_INSAFTER) begin
            mreq.next_ra = free_r;
          end else if (in_tuser == OP_ADVANCE || in_tuser == OP_DELAFTER) begin
            mreq.next_ra = cursor_r;
          end
          if (in_tuser == OP_READ) begin
            mreq.value_ra = cursor_r;
          end
          state_nxt = (in_tuser == OP_DISPOSE) ? ST_DISP : ST_EXEC;
        end
      end

      ST_EXEC: begin
        fin = 1'b1;
        case (op_r)
          OP_INSFIRST: begin
            if (!is_node(free_r)) begin
              res_sts = STS_FULL;
              err_nxt = 1'b1;
            end else begin
              free_nxt      = nn;
              mreq.value_we = 1'b1;
              mreq.value_wa = free_r;
              mreq.value_wd = val_r;
              mreq.next_we  = 1'b1;
              mreq.next_wa  = free_r;
              mreq.next_wd  = head_r;
              head_nxt      = free_r;
            end
          end
          OP_TOHEAD: begin
            cursor_nxt = head_r;
          end
          OP_READHEAD: begin
            if (is_node(head_r)) begin
              res_rd = to_read_value(value_rdata);
            end else begin
              res_sts = STS_EMPTY;
              err_nxt = 1'b1;
            end
          end
          OP_DELHEAD: begin
            if (is_node(head_r)) begin
              if (cursor_r == head_r) begin
                cursor_nxt = NIL;
              end
              head_nxt     = nn;
              mreq.next_we = 1'b1;
              mreq.next_wa = head_r;
              mreq.next_wd = free_r;
              free_nxt     = head_r;
            end
          end
          OP_DELAFTER: begin
            // fetch the link of the node that follows the cursor
            if (is_node(cursor_r) && is_node(nn)) begin
              fin          = 1'b0;
              tmp_nxt      = nn;
              mreq.next_ra = nn;
              state_nxt    = ST_DA2;
            end
          end
          OP_INSAFTER: begin
            if (is_node(cursor_r)) begin
              if (!is_node(free_r)) begin
                res_sts = STS_FULL;
                err_nxt = 1'b1;
              end else begin
                fin           = 1'b0;
                tmp_nxt       = free_r;
                free_nxt      = nn;
                mreq.value_we = 1'b1;
                mreq.value_wa = free_r;
                mreq.value_wd = val_r;
                mreq.next_ra  = cursor_r;
                state_nxt     = ST_IA2;
              end
            end
          end
          OP_READ: begin
            if (is_node(cursor_r)) begin
              res_rd = to_read_value(value_rdata);
            end else begin
              res_sts = STS_NO_CURSOR;
              err_nxt = 1'b1;
            end
          end
          OP_WRITE: begin
            if (is_node(cursor_r)) begin
              mreq.value_we = 1'b1;
              mreq.value_wa = cursor_r;
              mreq.value_wd = val_r;
            end
          end
          OP_ADVANCE: begin
            if (is_node(cursor_r)) begin
              cursor_nxt = nn;
            end
          end
          default: begin
            // query and unused codes leave the list alone
          end
        endcase
      end

      ST_DA2: begin
        // bypass the unlinked node
        mreq.next_we = 1'b1;
        mreq.next_wa = cursor_r;
        mreq.next_wd = nn;
        state_nxt    = ST_DA3;
      end

      ST_DA3: begin
        // push the unlinked node onto the free list
        mreq.next_we = 1'b1;
        mreq.next_wa = tmp_r;
        mreq.next_wd = free_r;
        free_nxt     = tmp_r;
        fin          = 1'b1;
      end

      ST_IA2: begin
        mreq.next_we = 1'b1;
        mreq.next_wa = tmp_r;
        mreq.next_wd = nn;
        state_nxt    = ST_IA3;
      end

      ST_IA3: begin
        mreq.next_we = 1'b1;
        mreq.next_wa = cursor_r;
        mreq.next_wd = tmp_r;
        fin          = 1'b1;
      end

      ST_DISP: begin
        // head walks the list; each node goes to the free list front
        // cursor drops with the first release so it never outlives the list
        if (is_node(head_r)) begin
          mreq.next_we = 1'b1;
          mreq.next_wa = head_r;
          mreq.next_wd = free_r;
          free_nxt     = head_r;
          head_nxt     = nn;
          cursor_nxt   = NIL;
          mreq.next_ra = nn;
        end else begin
          head_nxt   = NIL;
          cursor_nxt = NIL;
          fin        = 1'b1;
        end
      end

      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = pend_rd_r;
          out_act_nxt   = pend_act_r;
          out_sts_nxt   = pend_sts_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_rd_nxt    = res_rd;
        out_act_nxt   = is_node(cursor_nxt);
        out_sts_nxt   = res_sts;
        state_nxt     = ST_IDLE;
      end else begin
        pend_rd_nxt  = res_rd;
        pend_act_nxt = is_node(cursor_nxt);
        pend_sts_nxt = res_sts;
        state_nxt    = ST_HOLD;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_act_r, out_rd_r};
  assign out_tuser  = out_sts_r;

`ifndef SYNTH
  // a failed result always leaves the sticky error flag set
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STS_OK) |-> err_r)
    else $error("error result without sticky error flag");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STS_OK) |-> (out_tdata[31:0] == 32'd0))
    else $error("failed result carries a nonzero read value");

  // list and free list never start at the same node
  a_head_free: assert property (@(posedge clk) disable iff (!rst_n)
    is_node(head_r) |-> (head_r != free_r))
    else $error("head and free list share a node");

  // an active cursor implies a nonempty list
  a_cursor_list: assert property (@(posedge clk) disable iff (!rst_n)
    is_node(cursor_r) |-> is_node(head_r))
    else $error("cursor active on an empty list");

  a_link_write: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.next_we |-> is_node(mreq.next_wa))
    else $error("link write to the null index");
`endif

endmodule
